[design/dsl_byte_tokenizer_core_defines.svh]
// ----------------------------------------------------------------------------
// dsl_byte_tokenizer_core_defines
// Assertion macros shared by the tokenizer RTL. Expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DSL_BYTE_TOKENIZER_CORE_DEFINES_SVH
`define DSL_BYTE_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication
`define DBT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DBT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/dbt_pkg.sv]
// ----------------------------------------------------------------------------
// dbt_pkg
// Types, token codes and character tables for the DSL byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dbt_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int KW_NUM            = 7;
	localparam int KW_TEXT_LEN       = 8;
	localparam int FIFO_DEPTH        = 4;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_SPACE  = 3'd1,
		MODE_PATH   = 3'd2,
		MODE_STRING = 3'd3,
		MODE_IDENT  = 3'd4
	} mode_t;

	localparam logic [4:0] TK_END     = 5'd0;
	localparam logic [4:0] TK_EOL     = 5'd1;
	localparam logic [4:0] TK_SPACE   = 5'd2;
	localparam logic [4:0] TK_IDENT   = 5'd3;
	localparam logic [4:0] TK_STRING  = 5'd4;
	localparam logic [4:0] TK_PATH    = 5'd5;
	localparam logic [4:0] TK_SEMI    = 5'd6;
	localparam logic [4:0] TK_EQ      = 5'd7;
	localparam logic [4:0] TK_LBRACE  = 5'd8;
	localparam logic [4:0] TK_RBRACE  = 5'd9;
	localparam logic [4:0] TK_LBRACK  = 5'd10;
	localparam logic [4:0] TK_RBRACK  = 5'd11;
	localparam logic [4:0] TK_PLUS    = 5'd12;
	localparam logic [4:0] TK_MINUS   = 5'd13;
	localparam logic [4:0] TK_STAR    = 5'd14;
	localparam logic [4:0] TK_SLASH   = 5'd15;
	localparam logic [4:0] TK_KW_BASE = 5'd16;

	localparam byte_t KW_TEXT [KW_NUM][KW_TEXT_LEN] = '{
		'{"w", "e", "b", "s", "i", "t", "e", 8'h00},
		'{"d", "a", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "o", "g", "i", "c", 8'h00, 8'h00, 8'h00},
		'{"l", "o", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"u", "p", "d", "a", "t", "e", 8'h00, 8'h00},
		'{"a", "s", "s", "e", "r", "t", 8'h00, 8'h00},
		'{"i", "n", "c", "l", "u", "d", "e", 8'h00}
	};

	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd7, 3'd4, 3'd5, 3'd4, 3'd6, 3'd6, 3'd7};

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	function automatic logic is_alpha(input byte_t c);
		return (c inside {["a":"z"], ["A":"Z"]});
	endfunction

	function automatic logic is_alnum(input byte_t c);
		return is_alpha(c) || (c inside {["0":"9"]});
	endfunction

	function automatic logic is_space(input byte_t c);
		return (c inside {" ", 8'h09, 8'h0D});
	endfunction

endpackage

`default_nettype wire

[design/dsl_byte_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// dsl_byte_tokenizer_core
// Streaming tokenizer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   Source channel (src_valid/src_stall): one beat per source byte (kind = 0)
//   or an end-of-source beat (kind = 1) that closes any open run and yields an
//   end token of length 0, then rewinds the offset counter for a new source.
//   Token channel (tok_valid/tok_stall): one beat per token; last_of_run marks
//   the final token caused by a source beat. A byte that only extends a run
//   produces no token.
//   Flow: a source beat is captured in the input register, then classified
//   and written to the token queue once it has room, and its first token is
//   offered from the queue head.
//   Throughput: one source beat per cycle while the queue has room; one token
//   beat per cycle while tok_stall is low. A beat that yields two tokens
//   occupies two token beats. Source intake is gated by a four-entry token
//   queue: a byte is processed only while at most two entries are occupied.
//   Reset: scanner idle, offset zero, queue empty.
//   A stalled token channel holds its head token; once three entries are
//   occupied, a waiting source beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dsl_byte_tokenizer_core_defines.svh"

module dsl_byte_tokenizer_core #(
	parameter int POSITION_BITS = dbt_pkg::POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  char_byte,
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             last_of_run
);

	localparam int PTR_BITS = $clog2(dbt_pkg::FIFO_DEPTH);
	localparam int CNT_BITS = $clog2(dbt_pkg::FIFO_DEPTH + 1);

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [15:0] clamp16(input pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [dbt_pkg::KW_NUM-1:0] kw_update(
		input logic [dbt_pkg::KW_NUM-1:0] alive,
		input pos_t                       len,
		input dbt_pkg::byte_t             c
	);
		logic [dbt_pkg::KW_NUM-1:0] res;
		logic [31:0]                lw;
		res = alive;
		lw  = 32'(len);
		for (int k = 0; k < dbt_pkg::KW_NUM; k++) begin
			if (lw >= 32'(dbt_pkg::KW_LEN[k]))
				res[k] = 1'b0;
			else if (dbt_pkg::KW_TEXT[k][lw[2:0]] != c)
				res[k] = 1'b0;
		end
		return res;
	endfunction

	// input register
	logic                       valid_s1;
	logic                       kind_s1;
	dbt_pkg::byte_t             char_s1;

	// scanner state
	dbt_pkg::mode_t             mode_q, mode_d;
	pos_t                       pos_q, pos_d;
	pos_t                       rstart_q, rstart_d;
	pos_t                       rlen_q, rlen_d;
	logic [dbt_pkg::KW_NUM-1:0] alive_q, alive_d;

	// token queue
	dbt_pkg::tok_t              fifo_q [dbt_pkg::FIFO_DEPTH];
	logic [PTR_BITS-1:0]        rd_ptr_q, wr_ptr_q;
	logic [CNT_BITS-1:0]        cnt_q;

	logic                       proc;
	logic                       pop;
	logic                       ta_v, tb_v;
	dbt_pkg::tok_t              ta, tb;
	logic [4:0]                 run_kind;
	logic                       run_have;
	logic                       done;
	logic                       flush;
	pos_t                       flush_len;
	logic [1:0]                 push_n;
	dbt_pkg::tok_t              e0, e1;
	dbt_pkg::tok_t              head;

	assign proc      = valid_s1 && (cnt_q <= CNT_BITS'(dbt_pkg::FIFO_DEPTH - 2));
	assign src_stall = valid_s1 && !proc;
	assign pop       = tok_valid && !tok_stall;

	always_comb begin
		run_have = 1'b1;
		run_kind = dbt_pkg::TK_END;
		case (mode_q)
			dbt_pkg::MODE_SPACE:  run_kind = dbt_pkg::TK_SPACE;
			dbt_pkg::MODE_PATH:   run_kind = dbt_pkg::TK_PATH;
			dbt_pkg::MODE_STRING: run_kind = dbt_pkg::TK_STRING;
			dbt_pkg::MODE_IDENT: begin
				run_kind = dbt_pkg::TK_IDENT;
				for (int k = dbt_pkg::KW_NUM - 1; k >= 0; k--) begin
					if (alive_q[k] && (32'(rlen_q) == 32'(dbt_pkg::KW_LEN[k])))
						run_kind = dbt_pkg::TK_KW_BASE + 5'(k);
				end
			end
			default: run_have = 1'b0;
		endcase
	end

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		rstart_d  = rstart_q;
		rlen_d    = rlen_q;
		alive_d   = alive_q;
		done      = 1'b0;
		flush     = 1'b0;
		flush_len = rlen_q;
		tb_v      = 1'b0;
		tb        = '0;

		if (kind_s1) begin
			flush    = 1'b1;
			tb_v     = 1'b1;
			tb.kind  = dbt_pkg::TK_END;
			tb.start = clamp16(pos_q);
		end else begin
			case (mode_q)
				dbt_pkg::MODE_SPACE: begin
					if (dbt_pkg::is_space(char_s1)) begin
						rlen_d = sat_inc(rlen_q);
						done   = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				dbt_pkg::MODE_PATH: begin
					if (dbt_pkg::is_alnum(char_s1) || char_s1 == "\\" || char_s1 == "_") begin
						rlen_d = sat_inc(rlen_q);
						done   = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				dbt_pkg::MODE_STRING: begin
					rlen_d    = sat_inc(rlen_q);
					flush_len = sat_inc(rlen_q);
					flush     = (char_s1 == "\"");
					done      = 1'b1;
				end
				dbt_pkg::MODE_IDENT: begin
					if (dbt_pkg::is_alnum(char_s1) || char_s1 == "_") begin
						alive_d = kw_update(alive_q, rlen_q, char_s1);
						rlen_d  = sat_inc(rlen_q);
						done    = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				default: mode_d = dbt_pkg::MODE_IDLE;
			endcase
		end

		ta_v      = flush && run_have;
		ta        = '0;
		ta.kind   = run_kind;
		ta.start  = clamp16(rstart_q);
		ta.length = clamp16(flush_len);

		if (flush) begin
			mode_d  = dbt_pkg::MODE_IDLE;
			rlen_d  = '0;
			alive_d = '1;
		end

		if (kind_s1) begin
			pos_d    = '0;
			rstart_d = '0;
		end else begin
			if (!done) begin
				tb.start  = clamp16(pos_q);
				tb.length = 16'd1;
				tb_v      = 1'b1;
				case (char_s1)
					";":   tb.kind = dbt_pkg::TK_SEMI;
					"=":   tb.kind = dbt_pkg::TK_EQ;
					"{":   tb.kind = dbt_pkg::TK_LBRACE;
					"}":   tb.kind = dbt_pkg::TK_RBRACE;
					"[":   tb.kind = dbt_pkg::TK_LBRACK;
					"]":   tb.kind = dbt_pkg::TK_RBRACK;
					"+":   tb.kind = dbt_pkg::TK_PLUS;
					"-":   tb.kind = dbt_pkg::TK_MINUS;
					"*":   tb.kind = dbt_pkg::TK_STAR;
					"/":   tb.kind = dbt_pkg::TK_SLASH;
					8'h0A: tb.kind = dbt_pkg::TK_EOL;
					default: begin
						tb.kind = dbt_pkg::TK_END;
						if (dbt_pkg::is_space(char_s1) || char_s1 == "\\" || char_s1 == "\""
								|| dbt_pkg::is_alpha(char_s1) || char_s1 == "_") begin
							tb_v     = 1'b0;
							rstart_d = pos_q;
							rlen_d   = pos_t'(1);
							if (dbt_pkg::is_space(char_s1))
								mode_d = dbt_pkg::MODE_SPACE;
							else if (char_s1 == "\\")
								mode_d = dbt_pkg::MODE_PATH;
							else if (char_s1 == "\"")
								mode_d = dbt_pkg::MODE_STRING;
							else begin
								mode_d  = dbt_pkg::MODE_IDENT;
								alive_d = kw_update('1, '0, char_s1);
							end
						end
					end
				endcase
			end
			pos_d = sat_inc(pos_q);
		end

		ta.last = !tb_v;
		tb.last = 1'b1;
		e0      = ta_v ? ta : tb;
		e1      = tb;
		push_n  = 2'(ta_v) + 2'(tb_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= dbt_pkg::MODE_IDLE;
			pos_q    <= '0;
			rstart_q <= '0;
			rlen_q   <= '0;
			alive_q  <= '1;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (!src_stall)
				valid_s1 <= src_valid;
			if (proc) begin
				mode_q   <= mode_d;
				pos_q    <= pos_d;
				rstart_q <= rstart_d;
				rlen_q   <= rlen_d;
				alive_q  <= alive_d;
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			cnt_q <= cnt_q + (proc ? CNT_BITS'(push_n) : '0) - CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			kind_s1 <= kind;
			char_s1 <= char_byte;
		end
		if (proc && push_n != 2'd0)
			fifo_q[wr_ptr_q] <= e0;
		if (proc && push_n == 2'd2)
			fifo_q[wr_ptr_q + PTR_BITS'(1)] <= e1;
	end

	assign head         = fifo_q[rd_ptr_q];
	assign tok_valid    = (cnt_q != '0);
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

	`DBT_ASSERT_IMP(a_zero_len_end, tok_valid && token_length == 16'd0, token_kind == dbt_pkg::TK_END && last_of_run, "zero-length token is not a final end token")
	`DBT_ASSERT_NXT(a_end_rewinds, proc && kind_s1, mode_q == dbt_pkg::MODE_IDLE && pos_q == '0, "end of source did not rewind scanner")
	`DBT_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q <= CNT_BITS'(dbt_pkg::FIFO_DEPTH), "token queue overflow")
	`DBT_ASSERT_IMP(a_stall_full, src_stall, cnt_q > CNT_BITS'(dbt_pkg::FIFO_DEPTH - 2), "source stalled with queue room")

endmodule

`default_nettype wire

[bench/dsl_byte_tokenizer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsl_byte_tokenizer_core_test
// Self-checking bench for the byte tokenizer. A falling-edge driver offers
// source beats from a queue filled up front. A rising-edge monitor predicts
// the tokens of every accepted beat and checks the token stream field by
// field. Both channels idle at random and the token side holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module dsl_byte_tokenizer_core_test;

	localparam int QUIET_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 16;
	localparam int RANDOM_BEATS = 1850;
	localparam int LONG_HOLD    = 120;
	localparam int HOLD_AT      = 150;

	localparam logic [15:0] POS_TOP = 16'hFFFF;
	localparam logic [6:0]  KW_ALL  = 7'h7F;
	localparam logic [7:0]  CH_NL    = 8'h0A;
	localparam logic [7:0]  CH_TAB   = 8'h09;
	localparam logic [7:0]  CH_CR    = 8'h0D;
	localparam logic [7:0]  CH_BSL   = 8'h5C;
	localparam logic [7:0]  CH_QUOTE = 8'h22;
	localparam logic [7:0]  CH_US    = 8'h5F;

	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
		logic [2:0] gap;
		logic       drain;
	} src_beat_t;

	string kw_word [dbt_pkg::KW_NUM] = '{"website", "data", "logic", "load", "update",
		"assert", "include"};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic        kind = 1'b0;
	logic [7:0]  char_byte = 8'h00;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	// source beats still to offer, tokens still owed by the block
	src_beat_t     pending_beats [$];
	dbt_pkg::tok_t tokens_due [$];

	// scanner image
	dbt_pkg::mode_t scan_mode = dbt_pkg::MODE_IDLE;
	logic [15:0]    scan_pos = '0;
	logic [15:0]    run_from = '0;
	logic [15:0]    run_len = '0;
	logic [6:0]     kw_live = KW_ALL;

	logic      src_took = 1'b0;
	logic      tok_took = 1'b0;
	logic      offering = 1'b0;
	logic      loaded = 1'b0;
	src_beat_t cur_beat = '0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        tokens_seen = 0;
	int        quiet = 0;
	int        mismatches = 0;
	int        fed_beats = 0;
	logic      sender_calm = 1'b0;
	logic      drain_next = 1'b0;

	dsl_byte_tokenizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.kind         (kind),
		.char_byte    (char_byte),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_letter(c) || (c >= "0" && c <= "9") || c == CH_US;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == CH_TAB || c == CH_CR;
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == POS_TOP) ? v : v + 16'd1;
	endfunction

	function automatic void note_token(input logic [4:0] k, input logic [15:0] s,
		input logic [15:0] l);
		dbt_pkg::tok_t t;
		t.kind = k;
		t.start = s;
		t.length = l;
		t.last = 1'b0;
		tokens_due = {tokens_due, t};
	endfunction

	function automatic void kw_step(input logic [7:0] c);
		for (int k = 0; k < dbt_pkg::KW_NUM; k++) begin
			if (kw_live[k] && (run_len >= kw_word[k].len() || 8'(kw_word[k][run_len]) != c))
				kw_live[k] = 1'b0;
		end
	endfunction

	function automatic void open_run(input dbt_pkg::mode_t m);
		scan_mode = m;
		run_from = scan_pos;
		run_len = 16'd1;
	endfunction

	function automatic void close_run();
		logic [4:0] code;
		logic       have;
		have = 1'b1;
		code = dbt_pkg::TK_END;
		case (scan_mode)
			dbt_pkg::MODE_SPACE:  code = dbt_pkg::TK_SPACE;
			dbt_pkg::MODE_PATH:   code = dbt_pkg::TK_PATH;
			dbt_pkg::MODE_STRING: code = dbt_pkg::TK_STRING;
			dbt_pkg::MODE_IDENT: begin
				code = dbt_pkg::TK_IDENT;
				for (int k = 0; k < dbt_pkg::KW_NUM; k++) begin
					if (code == dbt_pkg::TK_IDENT && kw_live[k] && run_len == kw_word[k].len())
						code = dbt_pkg::TK_KW_BASE + 5'(k);
				end
			end
			default: have = 1'b0;
		endcase
		if (have)
			note_token(code, run_from, run_len);
		scan_mode = dbt_pkg::MODE_IDLE;
		run_len = '0;
		kw_live = KW_ALL;
	endfunction

	// tokens caused by one accepted source beat
	function automatic void scan_beat(input logic is_end, input logic [7:0] c);
		int            due_before;
		logic          extended;
		logic          is_single;
		logic [4:0]    single_code;
		dbt_pkg::tok_t tail;
		due_before = tokens_due.size();
		extended = 1'b0;
		is_single = 1'b1;
		single_code = dbt_pkg::TK_END;
		if (is_end) begin
			close_run();
			note_token(dbt_pkg::TK_END, scan_pos, 16'd0);
			scan_pos = '0;
			run_from = '0;
			run_len = '0;
			kw_live = KW_ALL;
			scan_mode = dbt_pkg::MODE_IDLE;
		end else begin
			case (scan_mode)
				dbt_pkg::MODE_SPACE:
					if (is_blank(c)) begin
						run_len = bump(run_len);
						extended = 1'b1;
					end else
						close_run();
				dbt_pkg::MODE_PATH:
					if (is_word(c) || c == CH_BSL) begin
						run_len = bump(run_len);
						extended = 1'b1;
					end else
						close_run();
				dbt_pkg::MODE_STRING: begin
					run_len = bump(run_len);
					if (c == CH_QUOTE)
						close_run();
					extended = 1'b1;
				end
				dbt_pkg::MODE_IDENT:
					if (is_word(c)) begin
						kw_step(c);
						run_len = bump(run_len);
						extended = 1'b1;
					end else
						close_run();
				default: scan_mode = dbt_pkg::MODE_IDLE;
			endcase
			if (!extended) begin
				case (c)
					";":   single_code = dbt_pkg::TK_SEMI;
					"=":   single_code = dbt_pkg::TK_EQ;
					"{":   single_code = dbt_pkg::TK_LBRACE;
					"}":   single_code = dbt_pkg::TK_RBRACE;
					"[":   single_code = dbt_pkg::TK_LBRACK;
					"]":   single_code = dbt_pkg::TK_RBRACK;
					"+":   single_code = dbt_pkg::TK_PLUS;
					"-":   single_code = dbt_pkg::TK_MINUS;
					"*":   single_code = dbt_pkg::TK_STAR;
					"/":   single_code = dbt_pkg::TK_SLASH;
					CH_NL: single_code = dbt_pkg::TK_EOL;
					default: is_single = 1'b0;
				endcase
				if (is_single)
					note_token(single_code, scan_pos, 16'd1);
				else if (is_blank(c))
					open_run(dbt_pkg::MODE_SPACE);
				else if (c == CH_BSL)
					open_run(dbt_pkg::MODE_PATH);
				else if (c == CH_QUOTE)
					open_run(dbt_pkg::MODE_STRING);
				else if (is_letter(c) || c == CH_US) begin
					kw_live = KW_ALL;
					run_len = '0;
					kw_step(c);
					open_run(dbt_pkg::MODE_IDENT);
				end else
					note_token(dbt_pkg::TK_END, scan_pos, 16'd1);
			end
			scan_pos = bump(scan_pos);
		end
		if (tokens_due.size() > due_before) begin
			tail = tokens_due[tokens_due.size() - 1];
			tail.last = 1'b1;
			tokens_due[tokens_due.size() - 1] = tail;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// ---- source stimulus helpers ----
	task automatic queue_beat(input logic is_end, input logic [7:0] c);
		src_beat_t b;
		b.is_end = is_end;
		b.ch = c;
		b.gap = sender_calm ? 3'd0 : 3'($urandom_range(0, 6));
		b.drain = drain_next;
		drain_next = 1'b0;
		pending_beats = {pending_beats, b};
		fed_beats++;
	endtask

	task automatic queue_byte(input logic [7:0] c);
		queue_beat(1'b0, c);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(8'(s[i]));
	endtask

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		else if (r < 62)
			return 8'("0" + r - 52);
		return CH_US;
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 2))
			0: return " ";
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] string_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CH_QUOTE) ? "q" : c;
	endfunction

	// ---- driver ----
	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && src_took) begin
				offering = 1'b0;
				loaded = 1'b0;
			end
			if (!loaded && pending_beats.size() != 0) begin
				cur_beat = pending_beats.pop_front();
				gap_left = cur_beat.gap;
				loaded = 1'b1;
			end
			if (loaded && !offering) begin
				if (gap_left != 0)
					gap_left--;
				else if (!cur_beat.drain || tokens_due.size() == 0)
					offering = 1'b1;
			end
			src_valid <= offering;
			kind <= cur_beat.is_end;
			char_byte <= cur_beat.ch;
		end
	end

	// ---- token receiver ----
	always @(negedge clk) begin
		if (arst_n) begin
			if (tok_took) begin
				tokens_seen++;
				if (tokens_seen == HOLD_AT)
					stall_left = LONG_HOLD;
				else if ((tokens_seen / 100) % 3 == 2)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 6);
			end
			tok_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// ---- monitor: predict on source beats, check token beats ----
	always @(posedge clk) begin : monitor
		dbt_pkg::tok_t want;
		if (arst_n) begin
			src_took <= src_valid && !src_stall;
			tok_took <= tok_valid && !tok_stall;
			if (src_valid && !src_stall)
				scan_beat(kind, char_byte);
			if (tok_valid && !tok_stall) begin
				if (tokens_due.size() == 0)
					report_mismatch($sformatf("token kind %0d start %0d len %0d, none pending",
						token_kind, token_start, token_length));
				else begin
					want = tokens_due.pop_front();
					if (token_kind !== want.kind)
						report_mismatch($sformatf("token_kind %0d, want %0d (start %0d)",
							token_kind, want.kind, want.start));
					if (token_start !== want.start)
						report_mismatch($sformatf("token_start %0d, want %0d (kind %0d)",
							token_start, want.start, want.kind));
					if (token_length !== want.length)
						report_mismatch($sformatf("token_length %0d, want %0d (start %0d)",
							token_length, want.length, want.start));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %0b, want %0b (start %0d)",
							last_of_run, want.last, want.start));
				end
			end
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
				quiet <= 0;
			else if (quiet >= QUIET_LIMIT) begin
				$display("dsl_byte_tokenizer_core_test NOT OK");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		int   goal;
		int   k;
		int   how;
		int   wlen;
		int   pos_at;
		int   idx;
		logic first_src;
		string puncts;
		puncts = ";={}[]+-*/";

		// directed: every single-byte token, runs, unknown bytes, unclosed string
		queue_text("{=}[]+-*/;");
		queue_byte(CH_NL);
		queue_byte(" ");
		queue_byte(CH_TAB);
		queue_byte(CH_CR);
		queue_byte(CH_BSL);
		queue_text("a_");
		queue_byte(CH_BSL);
		queue_byte(CH_QUOTE);
		queue_text("x");
		queue_byte(CH_QUOTE);
		queue_byte(8'h00);
		queue_byte(8'h80);
		queue_byte(8'hFF);
		queue_text("_9");
		queue_beat(1'b1, 8'hFF);
		queue_byte(CH_QUOTE);
		queue_text("ab");
		queue_beat(1'b1, 8'h00);

		goal = fed_beats + RANDOM_BEATS;
		first_src = 1'b1;
		while (fed_beats < goal) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			if (first_src || $urandom_range(0, 9) == 0)
				drain_next = 1'b1;
			first_src = 1'b0;
			repeat ($urandom_range(0, 14)) begin
				case ($urandom_range(0, 10))
					0, 1: begin
						queue_text(kw_word[$urandom_range(0, dbt_pkg::KW_NUM - 1)]);
						if ($urandom_range(0, 1) == 0)
							queue_byte(" ");
					end
					2: begin
						// keyword with one letter off, cut short or extended
						k = $urandom_range(0, dbt_pkg::KW_NUM - 1);
						how = $urandom_range(0, 3);
						wlen = kw_word[k].len();
						pos_at = $urandom_range(0, wlen - 1);
						for (int i = 0; i < wlen; i++) begin
							if (!(how == 0 && i == wlen - 1)) begin
								if (how == 2 && i == pos_at)
									queue_byte(word_char());
								else if (how == 3 && i == pos_at)
									queue_byte(8'(kw_word[k][i] - 8'h20));
								else
									queue_byte(8'(kw_word[k][i]));
							end
						end
						if (how == 1)
							queue_byte(word_char());
						queue_byte(blank_char());
					end
					3: begin
						queue_byte(($urandom_range(0, 7) == 0) ? CH_US :
							8'("a" + $urandom_range(0, 25)));
						repeat ($urandom_range(0, 10))
							queue_byte(word_char());
					end
					4: repeat ($urandom_range(1, 4)) queue_byte(blank_char());
					5: begin
						idx = $urandom_range(0, 10);
						queue_byte((idx == 10) ? CH_NL : 8'(puncts[idx]));
					end
					6: begin
						queue_byte(CH_BSL);
						repeat ($urandom_range(0, 6))
							queue_byte(($urandom_range(0, 4) == 0) ? CH_BSL : word_char());
					end
					7: begin
						queue_byte(CH_QUOTE);
						repeat ($urandom_range(0, 6))
							queue_byte(string_char());
						queue_byte(CH_QUOTE);
					end
					8: repeat ($urandom_range(1, 3)) queue_byte(8'("0" + $urandom_range(0, 9)));
					default: queue_byte(8'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 5) == 0) begin
				queue_byte(CH_QUOTE);
				repeat ($urandom_range(0, 4))
					queue_byte(string_char());
			end
			queue_beat(1'b1, 8'($urandom_range(0, 255)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || loaded)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("dsl_byte_tokenizer_core_test OK");
		else
			$display("dsl_byte_tokenizer_core_test NOT OK");
		$finish;
	end

endmodule
